FILE: design/bqf_pkg.sv
// Package for the biquad IIR filter: fixed widths, coefficient indexes,
// control word layout and the microcode table that sequences the datapath.
// No dependencies; used by design/biquad_iir_filter.sv.
package bqf_pkg;

    localparam int DEFAULT_SAMPLE_WIDTH   = 16;
    localparam int DEFAULT_COEF_FRAC_BITS = 16;

    // The accumulator is split into two halves for the feedback products.
    localparam int ACC_WIDTH  = 40;
    localparam int ACC_HALF   = ACC_WIDTH / 2;

    localparam int NUM_COEFS      = 5;
    localparam int CFG_ADDR_WIDTH = 3;
    localparam int STEP_WIDTH     = 4;

    typedef logic [CFG_ADDR_WIDTH-1:0] coef_idx_t;

    localparam coef_idx_t COEF_B0 = coef_idx_t'(0);
    localparam coef_idx_t COEF_B1 = coef_idx_t'(1);
    localparam coef_idx_t COEF_B2 = coef_idx_t'(2);
    localparam coef_idx_t COEF_A1 = coef_idx_t'(3);
    localparam coef_idx_t COEF_A2 = coef_idx_t'(4);

    // Second multiplier operand.
    typedef enum logic [1:0] {
        SRC_IN,     // sample on the input port
        SRC_X,      // captured sample
        SRC_ALO,    // low half of the accumulator, unsigned
        SRC_AHI     // high half of the accumulator, signed
    } mul_src_t;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_ACC,     // acc  <= sat(prod + delay_one)
        OP_OUT,     // result register <= sat(acc >>> F)
        OP_LOAD,    // sum  <= prod
        OP_FBH,     // fb   <= (sum + prod << half) >>> F
        OP_D1,      // delay_one <= sat(prod - fb + delay_two)
        OP_D2       // delay_two <= sat(prod - fb)
    } alu_op_t;

    typedef enum logic [1:0] {
        NX_SEQ,       // go to the following step
        NX_WAIT_IN,   // hold until a sample request is accepted
        NX_WAIT_OUT,  // hold until the result register is free
        NX_LAST       // return to the first step
    } next_t;

    typedef struct packed {
        coef_idx_t coef_sel;
        mul_src_t  src;
        alu_op_t   op;
        next_t     nxt;
    } ctrl_t;

    // The multiplier is registered, so a step consumes the product that the
    // step before it issued.
    function automatic ctrl_t ucode(input logic [STEP_WIDTH-1:0] step);
        ctrl_t cw;
        unique case (step)
            4'd0:    cw = '{COEF_B0, SRC_IN,  OP_NOP,  NX_WAIT_IN};
            4'd1:    cw = '{COEF_B0, SRC_X,   OP_ACC,  NX_SEQ};
            4'd2:    cw = '{COEF_A1, SRC_ALO, OP_OUT,  NX_WAIT_OUT};
            4'd3:    cw = '{COEF_A1, SRC_AHI, OP_LOAD, NX_SEQ};
            4'd4:    cw = '{COEF_B1, SRC_X,   OP_FBH,  NX_SEQ};
            4'd5:    cw = '{COEF_A2, SRC_ALO, OP_D1,   NX_SEQ};
            4'd6:    cw = '{COEF_A2, SRC_AHI, OP_LOAD, NX_SEQ};
            4'd7:    cw = '{COEF_B2, SRC_X,   OP_FBH,  NX_SEQ};
            4'd8:    cw = '{COEF_B2, SRC_X,   OP_D2,   NX_LAST};
            default: cw = '{COEF_B0, SRC_X,   OP_NOP,  NX_LAST};
        endcase
        return cw;
    endfunction

endpackage

FILE: design/biquad_iir_filter.sv
// Biquad IIR filter, transposed direct form II, run by a microcoded sequencer
// over one shared registered multiplier and a wide add/saturate datapath.
// Depends on design/bqf_pkg.sv.
//
// Usage:
//   Samples arrive on the s_ stream channel, one signed sample per request in
//   the low bits of s_tdata; filtered samples leave on the m_ channel in the
//   low bits of m_tdata, the upper padding bits being zero.
//   Coefficients b0, b1, b2, a1, a2 (indexes 0 to 4, signed Q3.F) are written
//   through cfg_wr_en/cfg_addr/cfg_wdata while no sample is in flight; writes
//   to other indexes are dropped.
//   For each sample the sequencer runs nine control steps and issues three
//   feedforward products plus the two feedback products, each of those split
//   into two half-word passes, on the single multiplier.
//   s_tready is high only in the first step.
//   The result passes through the accumulator and then the output register,
//   where it sits, so the next sample can be taken while it waits.
//   If the receiver stalls, the following sample stops at its output step
//   until the register is free; nothing is dropped.
//   Reset restores b0 = 1.0, the other coefficients to zero, clears both
//   delay accumulators and empties the output register.
module biquad_iir_filter #(
    parameter int SAMPLE_WIDTH   = bqf_pkg::DEFAULT_SAMPLE_WIDTH,
    parameter int COEF_FRAC_BITS = bqf_pkg::DEFAULT_COEF_FRAC_BITS,
    localparam int CW  = COEF_FRAC_BITS + 4,
    localparam int TDW = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // Input stream. s_tdata: sample_in.
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [TDW-1:0]                     s_tdata,
    // Output stream. m_tdata: sample_out.
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [TDW-1:0]                     m_tdata,
    // Coefficient write port.
    input  logic                               cfg_wr_en,
    input  logic [bqf_pkg::CFG_ADDR_WIDTH-1:0] cfg_addr,
    input  logic [CW-1:0]                      cfg_wdata
);

    localparam int ACC  = bqf_pkg::ACC_WIDTH;
    localparam int HALF = bqf_pkg::ACC_HALF;
    localparam int F    = COEF_FRAC_BITS;
    localparam int BW   = (SAMPLE_WIDTH > HALF + 1) ? SAMPLE_WIDTH : HALF + 1;
    localparam int PW   = CW + BW;
    localparam int SUMW = CW + ACC;
    localparam int FBW  = SUMW - F;
    localparam int DW   = ((PW > FBW) ? PW : FBW) + 2;
    localparam int SHW  = ACC - F;

    // Sequencer
    logic [bqf_pkg::STEP_WIDTH-1:0] step_reg, step_next;
    bqf_pkg::ctrl_t                 cw;
    logic                           s_accept;
    logic                           out_free;

    // Datapath
    logic signed [CW-1:0]           coef_reg [bqf_pkg::NUM_COEFS];
    logic signed [CW-1:0]           coef_sel;
    logic signed [SAMPLE_WIDTH-1:0] x_reg;
    logic signed [BW-1:0]           opb;
    logic signed [PW-1:0]           prod_reg;
    logic signed [SUMW-1:0]         sum_reg;
    logic signed [SUMW-1:0]         fb_sum;
    logic signed [FBW-1:0]          fb_reg;
    logic signed [ACC-1:0]          acc_reg;
    logic signed [ACC-1:0]          delay_one_reg;
    logic signed [ACC-1:0]          delay_two_reg;
    logic signed [DW-1:0]           prod_ext;
    logic signed [DW-1:0]           acc_sum;
    logic signed [DW-1:0]           d1_sum;
    logic signed [DW-1:0]           d2_sum;
    logic signed [SHW-1:0]          acc_shift;
    logic signed [SAMPLE_WIDTH-1:0] y_sat;
    logic [SAMPLE_WIDTH-1:0]        out_reg;
    logic                           out_valid_reg;

    function automatic logic signed [ACC-1:0] sat_acc(input logic signed [DW-1:0] v);
        logic signed [ACC-1:0] r;
        if (&v[DW-1:ACC-1] || ~|v[DW-1:ACC-1]) begin
            r = v[ACC-1:0];
        end else if (v[DW-1]) begin
            r = {1'b1, {(ACC-1){1'b0}}};
        end else begin
            r = {1'b0, {(ACC-1){1'b1}}};
        end
        return r;
    endfunction

    assign cw       = bqf_pkg::ucode(step_reg);
    assign s_tready = (cw.nxt == bqf_pkg::NX_WAIT_IN);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;

    always_comb begin
        unique case (cw.nxt)
            bqf_pkg::NX_SEQ:      step_next = step_reg + 1'b1;
            bqf_pkg::NX_WAIT_IN:  step_next = s_accept ? step_reg + 1'b1 : step_reg;
            bqf_pkg::NX_WAIT_OUT: step_next = out_free ? step_reg + 1'b1 : step_reg;
            bqf_pkg::NX_LAST:     step_next = '0;
            default:              step_next = '0;
        endcase
    end

    // Multiplier operands
    assign coef_sel = coef_reg[cw.coef_sel];

    always_comb begin
        unique case (cw.src)
            bqf_pkg::SRC_IN:  opb = BW'(signed'(s_tdata[SAMPLE_WIDTH-1:0]));
            bqf_pkg::SRC_X:   opb = BW'(x_reg);
            bqf_pkg::SRC_ALO: opb = signed'(BW'({1'b0, acc_reg[HALF-1:0]}));
            bqf_pkg::SRC_AHI: opb = BW'(signed'(acc_reg[ACC-1:HALF]));
            default:          opb = '0;
        endcase
    end

    // Adders; the high-half feedback product lands HALF bits up, and the
    // floor shift by F is taken from the full-precision sum.
    assign prod_ext = DW'(prod_reg);
    assign fb_sum   = sum_reg + (SUMW'(prod_reg) <<< HALF);
    assign acc_sum  = prod_ext + DW'(delay_one_reg);
    assign d1_sum   = prod_ext - DW'(fb_reg) + DW'(delay_two_reg);
    assign d2_sum   = prod_ext - DW'(fb_reg);

    // Output of acc >>> F at the sample width, saturated when the shifted value is wider.
    assign acc_shift = acc_reg[ACC-1:F];

    generate
        if (SHW > SAMPLE_WIDTH) begin : g_out_sat
            always_comb begin
                if (&acc_shift[SHW-1:SAMPLE_WIDTH-1] || ~|acc_shift[SHW-1:SAMPLE_WIDTH-1]) begin
                    y_sat = acc_shift[SAMPLE_WIDTH-1:0];
                end else if (acc_shift[SHW-1]) begin
                    y_sat = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
                end else begin
                    y_sat = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
                end
            end
        end else begin : g_out_ext
            assign y_sat = SAMPLE_WIDTH'(acc_shift);
        end
    endgenerate

    // Control state, coefficients and delay accumulators
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
            delay_one_reg <= '0;
            delay_two_reg <= '0;
            for (int i = 0; i < bqf_pkg::NUM_COEFS; i++) begin
                coef_reg[i] <= (i == int'(bqf_pkg::COEF_B0)) ? (CW'(1) <<< F) : CW'(0);
            end
        end else begin
            step_reg <= step_next;
            if (cfg_wr_en && (cfg_addr < bqf_pkg::CFG_ADDR_WIDTH'(bqf_pkg::NUM_COEFS))) begin
                coef_reg[cfg_addr] <= cfg_wdata;
            end
            if (cw.op == bqf_pkg::OP_OUT && out_free) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (cw.op == bqf_pkg::OP_D1) begin
                delay_one_reg <= sat_acc(d1_sum);
            end
            if (cw.op == bqf_pkg::OP_D2) begin
                delay_two_reg <= sat_acc(d2_sum);
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        prod_reg <= PW'(coef_sel * opb);
        if (s_accept) begin
            x_reg <= signed'(s_tdata[SAMPLE_WIDTH-1:0]);
        end
        if (cw.op == bqf_pkg::OP_ACC) begin
            acc_reg <= sat_acc(acc_sum);
        end
        if (cw.op == bqf_pkg::OP_LOAD) begin
            sum_reg <= SUMW'(prod_reg);
        end
        if (cw.op == bqf_pkg::OP_FBH) begin
            fb_reg <= fb_sum[SUMW-1:F];
        end
        if (cw.op == bqf_pkg::OP_OUT && out_free) begin
            out_reg <= y_sat;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = TDW'(out_reg);

endmodule
